// ===== sv/itr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itr_pkg
// shared types, constants and helpers for the integer-to-radix text unit
// ----------------------------------------------------------------------------
package itr_pkg;

  localparam int MAX_RADIX   = 16;
  localparam int VALUE_W     = 32;
  localparam int CHAR_W      = 8;
  localparam int RADIX_W     = 5;
  localparam int ALPHA_W     = 64;
  localparam int STACK_DEPTH = 32;
  localparam int STACK_PTR_W = 5;
  localparam int STACK_CNT_W = 6;
  localparam int BITS_PER_STEP = 8;
  localparam int DIV_STEPS   = VALUE_W / BITS_PER_STEP;
  localparam int DIV_CNT_W   = 2;

  localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'd43;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'd45;
  localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'd32;
  localparam logic [CHAR_W-1:0] CHAR_DEL   = 8'd127;

  localparam logic [1:0] REG_RADIX_LENGTH  = 2'd0;
  localparam logic [1:0] REG_ALPHABET_LOW  = 2'd1;
  localparam logic [1:0] REG_ALPHABET_HIGH = 2'd2;

  typedef struct packed {
    logic               start;
    logic [VALUE_W-1:0] dividend;
    logic [RADIX_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [VALUE_W-1:0] quotient;
    logic [RADIX_W-1:0] remainder;
  } div_resp_t;

  typedef struct packed {
    logic              push;
    logic              pop;
    logic [CHAR_W-1:0] data;
  } stk_ctl_t;

  // character k of the alphabet held in two 64-bit words
  function automatic logic [CHAR_W-1:0] glyph(input logic [ALPHA_W-1:0] lo,
                                              input logic [ALPHA_W-1:0] hi,
                                              input logic [3:0]         k);
    logic [ALPHA_W-1:0] word;
    word = k[3] ? hi : lo;
    return word[k[2:0]*CHAR_W +: CHAR_W];
  endfunction

endpackage

// ===== sv/itr_divider.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itr_divider
// shared restoring divider, 32-bit dividend by a radix of up to 16,
// eight quotient bits per cycle
// ----------------------------------------------------------------------------
module itr_divider
  import itr_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  div_req_t  req,
  output div_resp_t resp
);

  logic                 busy;
  logic [DIV_CNT_W-1:0] cnt;
  logic [VALUE_W-1:0]   num;
  logic [RADIX_W-1:0]   rem;
  logic [RADIX_W-1:0]   dsr;

  logic [VALUE_W-1:0]   num_next;
  logic [RADIX_W-1:0]   rem_next;

  // eight shift-compare-subtract steps on a narrow partial remainder
  always_comb begin
    logic [VALUE_W-1:0] n;
    logic [RADIX_W-1:0] r;
    n = num;
    r = rem;
    for (int k = 0; k < BITS_PER_STEP; k++) begin
      r = {r[RADIX_W-2:0], n[VALUE_W-1]};
      n = {n[VALUE_W-2:0], 1'b0};
      if (r >= dsr) begin
        r    = r - dsr;
        n[0] = 1'b1;
      end
    end
    num_next = n;
    rem_next = r;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (req.start) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (cnt == DIV_CNT_W'(DIV_STEPS - 1)) busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      num <= req.dividend;
      rem <= '0;
      dsr <= req.divisor;
    end else if (busy) begin
      num <= num_next;
      rem <= rem_next;
    end
  end

  assign resp.done      = busy && (cnt == DIV_CNT_W'(DIV_STEPS - 1));
  assign resp.quotient  = num_next;
  assign resp.remainder = rem_next;

endmodule

// ===== sv/itr_digit_stack.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itr_digit_stack
// last-in first-out store of digit characters, least significant pushed first
// ----------------------------------------------------------------------------
module itr_digit_stack
  import itr_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  stk_ctl_t               ctl,
  output logic [CHAR_W-1:0]      top,
  output logic [STACK_CNT_W-1:0] count
);

  logic [CHAR_W-1:0]      mem [STACK_DEPTH];
  logic [STACK_PTR_W-1:0] top_ptr;

  assign top_ptr = count[STACK_PTR_W-1:0] - 1'b1;
  assign top     = mem[top_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (ctl.push) begin
      count <= count + 1'b1;
    end else if (ctl.pop) begin
      count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.push) mem[count[STACK_PTR_W-1:0]] <= ctl.data;
  end

endmodule

// ===== sv/integer_to_radix_text_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_to_radix_text_unit
// converts a signed 32-bit integer to text in a radix set by a configured
// alphabet; minus sign first, then digits most significant first
// ----------------------------------------------------------------------------
// order: every digit is divided out and stacked before the minus sign of a
//   negative value or the first digit of any other is output
// flow: one item at a time; a new value is taken only once the sequencer is
//   idle again, after the last character is loaded into the output register
// reset: synchronous, restores radix 10 with alphabet "0123456789" and idles
// ----------------------------------------------------------------------------
module integer_to_radix_text_unit
  import itr_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  // input channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [VALUE_W-1:0] value,
  // output channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic [CHAR_W-1:0]  text_char,
  output logic               last_char,
  // configuration write port
  input  logic               cfg_write,
  input  logic [1:0]         cfg_index,
  input  logic [ALPHA_W-1:0] cfg_data
);

  // sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_START = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_SIGN  = 3'd4;
  localparam logic [2:0] S_EMIT  = 3'd5;

  logic [2:0]               state;
  logic [2:0]               state_next;

  // configuration registers
  logic [RADIX_W-1:0]       radix_length;
  logic [ALPHA_W-1:0]       alphabet_low;
  logic [ALPHA_W-1:0]       alphabet_high;

  // item registers
  logic                     neg;
  logic [VALUE_W-1:0]       mag;

  div_req_t                 div_req;
  div_resp_t                div_resp;
  stk_ctl_t                 stk_ctl;
  logic [CHAR_W-1:0]        stk_top;
  logic [STACK_CNT_W-1:0]   stk_count;

  logic                     alpha_ok;
  logic                     out_free;
  logic                     out_load;
  logic [CHAR_W-1:0]        out_char_next;
  logic                     out_last_next;
  logic                     more_digits;
  logic                     in_accept;

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk) begin
    if (rst) begin
      radix_length  <= RADIX_W'(10);
      alphabet_low  <= 64'h3736_3534_3332_3130;
      alphabet_high <= 64'h0000_0000_0000_3938;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_RADIX_LENGTH:  radix_length  <= cfg_data[RADIX_W-1:0];
        REG_ALPHABET_LOW:  alphabet_low  <= cfg_data;
        REG_ALPHABET_HIGH: alphabet_high <= cfg_data;
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  // ------------------------------------------------------- alphabet check
  // radix 2..16; every char in use above space, not DEL or a sign, unique
  always_comb begin
    logic [CHAR_W-1:0] ci;
    logic [CHAR_W-1:0] cj;
    alpha_ok = (radix_length >= RADIX_W'(2)) && (radix_length <= RADIX_W'(MAX_RADIX));
    for (int i = 0; i < MAX_RADIX; i++) begin
      ci = glyph(alphabet_low, alphabet_high, 4'(i));
      if (RADIX_W'(i) < radix_length) begin
        if (ci == CHAR_PLUS || ci == CHAR_MINUS || ci <= CHAR_SPACE || ci == CHAR_DEL)
          alpha_ok = 1'b0;
      end
      for (int j = i + 1; j < MAX_RADIX; j++) begin
        cj = glyph(alphabet_low, alphabet_high, 4'(j));
        if (RADIX_W'(j) < radix_length && ci == cj) alpha_ok = 1'b0;
      end
    end
  end

  // ---------------------------------------------------------- shared units
  itr_divider u_div (
    .clk  (clk),
    .rst  (rst),
    .req  (div_req),
    .resp (div_resp)
  );

  itr_digit_stack u_stack (
    .clk   (clk),
    .rst   (rst),
    .ctl   (stk_ctl),
    .top   (stk_top),
    .count (stk_count)
  );

  // stop once the quotient is zero or every digit slot is used
  assign more_digits = (div_resp.quotient != '0) &&
                       (stk_count != STACK_CNT_W'(STACK_DEPTH - 1));

  assign in_stall  = (state != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;

  // ------------------------------------------------------------ sequencer
  always_comb begin
    state_next       = state;
    div_req.start    = 1'b0;
    div_req.dividend = (state == S_START) ? mag : div_resp.quotient;
    div_req.divisor  = radix_length;
    stk_ctl.push     = 1'b0;
    stk_ctl.pop      = 1'b0;
    stk_ctl.data     = glyph(alphabet_low, alphabet_high, div_resp.remainder[3:0]);
    out_load         = 1'b0;
    out_char_next    = stk_top;
    out_last_next    = (stk_count == STACK_CNT_W'(1));

    case (state)
      S_IDLE: begin
        if (in_accept) state_next = S_CHECK;
      end
      S_CHECK: begin
        // invalid alphabet: drop the item without output
        state_next = alpha_ok ? S_START : S_IDLE;
      end
      S_START: begin
        div_req.start = 1'b1;
        state_next    = S_DIV;
      end
      S_DIV: begin
        if (div_resp.done) begin
          stk_ctl.push = 1'b1;
          if (more_digits) begin
            div_req.start = 1'b1;   // chain straight into the next digit
          end else begin
            state_next = S_SIGN;
          end
        end
      end
      S_SIGN: begin
        if (!neg) begin
          state_next = S_EMIT;
        end else if (out_free) begin
          out_load      = 1'b1;
          out_char_next = CHAR_MINUS;
          out_last_next = 1'b0;
          state_next    = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_load    = 1'b1;
          stk_ctl.pop = 1'b1;
          if (stk_count == STACK_CNT_W'(1)) state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // capture sign and magnitude; 2^31 falls out of the unsigned negate
  always_ff @(posedge clk) begin
    if (in_accept) begin
      neg <= value[VALUE_W-1];
      mag <= value[VALUE_W-1] ? (VALUE_W'(0) - value) : value;
    end
  end

  // ------------------------------------------------------ output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      text_char <= out_char_next;
      last_char <= out_last_next;
    end
  end

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// checks integer_to_radix_text_unit beat by beat against a local predictor of
// the radix text conversion: directed corner values and alphabets, then
// random alphabets and values under three sender/receiver idling regimes
// ----------------------------------------------------------------------------
module testbench;
  import itr_pkg::*;

  // index 3 is decoded by nobody, writes to it must be dropped
  localparam logic [1:0] REG_UNUSED = 2'd3;

  // binary conversion of a full 32-digit value is the slowest item
  localparam int SETTLE_CYCLES = 200;
  localparam int TIMEOUT_NS    = 2_000_000;

  // one expected character beat
  typedef struct {
    logic [CHAR_W-1:0] ch;
    logic              last;
  } text_beat_t;

  logic               clk       = 1'b0;
  logic               rst       = 1'b1;
  logic               in_valid  = 1'b0;
  logic               in_stall;
  logic [VALUE_W-1:0] value     = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [CHAR_W-1:0]  text_char;
  logic               last_char;
  logic               cfg_write = 1'b0;
  logic [1:0]         cfg_index = REG_RADIX_LENGTH;
  logic [ALPHA_W-1:0] cfg_data  = '0;

  // local copy of the configuration, reset values of the block
  logic [RADIX_W-1:0] cur_radix = 5'd10;
  logic [ALPHA_W-1:0] cur_lo    = 64'h3736_3534_3332_3130;
  logic [ALPHA_W-1:0] cur_hi    = 64'h0000_0000_0000_3938;

  text_beat_t expected_text[$];
  int         fault_count    = 0;
  int         send_gap_pct   = 0;
  int         recv_stall_pct = 0;

  integer_to_radix_text_unit dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .value     (value),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .text_char (text_char),
    .last_char (last_char),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // 2 ns period
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ------------------------------------------------------------------------
  // predictor
  // ------------------------------------------------------------------------

  // character k of the current alphabet
  function automatic logic [CHAR_W-1:0] char_at(input int k);
    logic [ALPHA_W-1:0] word;
    word = (k < 8) ? cur_lo : cur_hi;
    return word[(k % 8) * CHAR_W +: CHAR_W];
  endfunction

  // radix in range, no sign or control characters, no repeats
  function automatic bit alphabet_valid();
    int          n;
    int          i;
    int          j;
    logic [7:0]  c;
    n = int'(cur_radix);
    if (n < 2 || n > MAX_RADIX) return 1'b0;
    for (i = 0; i < n; i++) begin
      c = char_at(i);
      if (c == CHAR_PLUS || c == CHAR_MINUS || c <= CHAR_SPACE || c == CHAR_DEL)
        return 1'b0;
      for (j = i + 1; j < n; j++)
        if (char_at(j) == c) return 1'b0;
    end
    return 1'b1;
  endfunction

  // append the text of v to the expected beats; nothing for a bad alphabet
  function automatic void queue_text_of(input logic [VALUE_W-1:0] v);
    logic [VALUE_W-1:0] mag;
    logic [CHAR_W-1:0]  digits[32];
    int                 nd;
    text_beat_t         b;
    if (!alphabet_valid()) return;
    // two's complement negate, so the most negative value becomes 2^31
    mag = v[VALUE_W-1] ? (32'd0 - v) : v;
    nd  = 0;
    do begin
      digits[nd] = char_at(int'(mag % cur_radix));
      mag = mag / cur_radix;
      nd++;
    end while (mag != 0);
    if (v[VALUE_W-1]) begin
      b.ch   = CHAR_MINUS;
      b.last = 1'b0;
      expected_text.push_back(b);
    end
    while (nd > 0) begin
      nd--;
      b.ch   = digits[nd];
      b.last = (nd == 0);
      expected_text.push_back(b);
    end
  endfunction

  // ------------------------------------------------------------------------
  // output side: random stall, then compare each accepted beat
  // ------------------------------------------------------------------------
  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    text_beat_t want;
    if (!rst && out_valid === 1'b1 && !out_stall) begin
      if (expected_text.size() == 0) begin
        // beat with nothing waiting for it
        if (fault_count < 10)
          $display("unexpected beat: char %h last %b", text_char, last_char);
        fault_count++;
      end else begin
        want = expected_text.pop_front();
        if (want.ch !== text_char || want.last !== last_char) begin
          if (fault_count < 10)
            $display("mismatch: expected char %h last %b, got char %h last %b",
                     want.ch, want.last, text_char, last_char);
          fault_count++;
        end
      end
    end
  end

  // ------------------------------------------------------------------------
  // stimulus helpers; every task is entered and left just after a falling edge
  // ------------------------------------------------------------------------

  // send one value, with random gaps in front of it
  task automatic send_value(input logic [VALUE_W-1:0] v);
    while ($urandom_range(0, 99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    value    <= v;
    // the beat is taken at the first rising edge without stall
    do @(posedge clk); while (in_stall);
    queue_text_of(v);
    @(negedge clk);
  endtask

  // stop sending until every expected beat has arrived
  task automatic hold_until_drained();
    in_valid <= 1'b0;
    do @(negedge clk); while (expected_text.size() != 0);
  endtask

  // drained, plus time for an item with no output to finish
  task automatic drain_and_settle();
    hold_until_drained();
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // register write, only once the block is idle
  task automatic write_reg(input logic [1:0] idx, input logic [ALPHA_W-1:0] data);
    drain_and_settle();
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      REG_RADIX_LENGTH:  cur_radix = data[RADIX_W-1:0];
      REG_ALPHABET_LOW:  cur_lo    = data;
      REG_ALPHABET_HIGH: cur_hi    = data;
      default: ;  // dropped by the block
    endcase
    @(negedge clk);
    cfg_write <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_alphabet(input logic [ALPHA_W-1:0] radix_data,
                              input logic [ALPHA_W-1:0] lo,
                              input logic [ALPHA_W-1:0] hi);
    write_reg(REG_RADIX_LENGTH, radix_data);
    write_reg(REG_ALPHABET_LOW, lo);
    write_reg(REG_ALPHABET_HIGH, hi);
  endtask

  // random alphabet, mostly valid, sometimes broken in one way
  task automatic pick_random_config();
    logic [127:0]       alpha;
    logic [ALPHA_W-1:0] rdata;
    bit                 used[256];
    int                 n;
    int                 k;
    int                 j;
    int                 c;
    alpha = {$urandom, $urandom, $urandom, $urandom};
    n     = $urandom_range(2, MAX_RADIX);
    for (k = 0; k < n; k++) begin
      do c = $urandom_range(33, 255);
      while (c == CHAR_PLUS || c == CHAR_MINUS || c == CHAR_DEL || used[c]);
      used[c] = 1'b1;
      alpha[k*8 +: 8] = 8'(c);
    end
    if ($urandom_range(0, 5) == 0) begin
      k = $urandom_range(0, n - 1);
      case ($urandom_range(0, 3))
        0: begin
          // radix out of range
          n = $urandom_range(0, 1) ? $urandom_range(0, 1) : $urandom_range(17, 31);
        end
        1: begin
          // control character or space
          alpha[k*8 +: 8] = 8'($urandom_range(0, 32));
        end
        2: begin
          case ($urandom_range(0, 2))
            0:       alpha[k*8 +: 8] = CHAR_PLUS;
            1:       alpha[k*8 +: 8] = CHAR_MINUS;
            default: alpha[k*8 +: 8] = CHAR_DEL;
          endcase
        end
        default: begin
          // repeated character
          j = (k + 1 + $urandom_range(0, n - 2)) % n;
          alpha[j*8 +: 8] = alpha[k*8 +: 8];
        end
      endcase
    end
    // upper bits of the radix word are don't-care
    rdata = {$urandom, $urandom};
    rdata[RADIX_W-1:0] = RADIX_W'(n);
    set_alphabet(rdata, alpha[63:0], alpha[127:64]);
    if ($urandom_range(0, 3) == 0) write_reg(REG_UNUSED, {$urandom, $urandom});
  endtask

  // mix of full-range, small, extreme and shortened values
  function automatic logic [VALUE_W-1:0] random_value();
    logic [VALUE_W-1:0] v;
    case ($urandom_range(0, 5))
      0: v = $urandom_range(0, 40);
      1: v = 32'd0 - $urandom_range(1, 40);
      2: begin
        case ($urandom_range(0, 3))
          0:       v = 32'h8000_0000;
          1:       v = 32'h7FFF_FFFF;
          2:       v = 32'hFFFF_FFFF;
          default: v = 32'h0000_0000;
        endcase
      end
      3: begin
        v = $urandom >> $urandom_range(0, 31);
        if ($urandom_range(0, 1)) v = 32'd0 - v;
      end
      default: v = $urandom;
    endcase
    return v;
  endfunction

  // ------------------------------------------------------------------------
  // tests
  // ------------------------------------------------------------------------

  // decimal alphabet straight out of reset
  task automatic test_reset_decimal();
    send_value(32'd0);
    send_value(32'd7);
    send_value(32'hFFFF_FFFF);
    send_value(32'h7FFF_FFFF);
    send_value(32'h8000_0000);
    send_value(32'd1_000_000_000);
  endtask

  // a write to the unused index changes nothing
  task automatic test_unused_index();
    write_reg(REG_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF);
    send_value(32'd12345);
  endtask

  // smallest and largest radix, and high-byte characters
  task automatic test_radix_extremes();
    // binary; only the low five bits of the radix word count
    set_alphabet(64'hFFFF_FFFF_FFFF_FFE2, 64'h0000_0000_0000_3130, 64'h0);
    send_value(32'h8000_0000);  // minus sign and 32 digits
    send_value(32'h7FFF_FFFF);
    send_value(32'd0);
    // hexadecimal
    set_alphabet(64'd16, 64'h3736_3534_3332_3130, 64'h4645_4443_4241_3938);
    send_value(32'h8000_0000);
    send_value(32'hDEAD_BEEF);
    send_value(32'd15);
    // lowest printable, tilde and bytes above 127 are all legal digits
    set_alphabet(64'd16, 64'hDFC0_FFFE_8180_7E21, 64'hF3F2_F1F0_E7B6_A590);
    send_value(32'h89AB_CDEF);
    send_value(32'hFFFF_FFFF);
  endtask

  // every kind of invalid alphabet gives no text at all
  task automatic test_bad_alphabets();
    set_alphabet(64'd0, 64'h3736_3534_3332_3130, 64'h3938);
    send_value(32'd5);
    write_reg(REG_RADIX_LENGTH, 64'd1);
    send_value(32'hFFFF_FFF0);
    write_reg(REG_RADIX_LENGTH, 64'd17);
    send_value(32'd100);
    write_reg(REG_RADIX_LENGTH, 64'd31);
    send_value(32'h8000_0000);
    // plus sign inside the alphabet
    set_alphabet(64'd10, 64'h3736_3534_2B32_3130, 64'h3938);
    send_value(32'd42);
    // minus sign as the last digit
    set_alphabet(64'd10, 64'h3736_3534_3332_3130, 64'h2D38);
    send_value(32'd42);
    // space as the first digit
    set_alphabet(64'd10, 64'h3736_3534_3332_3120, 64'h3938);
    send_value(32'hFFFF_FFD6);
    // null byte
    set_alphabet(64'd10, 64'h0036_3534_3332_3130, 64'h3938);
    send_value(32'd9);
    // delete character
    set_alphabet(64'd10, 64'h3736_7F34_3332_3130, 64'h3938);
    send_value(32'd9);
    // repeated digit
    set_alphabet(64'd10, 64'h3736_3534_3338_3130, 64'h3938);
    send_value(32'd88);
    // a bad byte past the radix is not looked at
    set_alphabet(64'd10, 64'h3736_3534_3332_3130, 64'h2B_3938);
    send_value(32'd2024);
  endtask

  task automatic run_traffic_phase(input int gap_pct, input int stall_pct, input int items);
    int sent;
    int seg;
    int i;
    send_gap_pct   = gap_pct;
    recv_stall_pct = stall_pct;
    sent = 0;
    while (sent < items) begin
      pick_random_config();
      seg = $urandom_range(6, 14);
      for (i = 0; i < seg && sent < items; i++) begin
        // the sender waits for the output to run dry now and then
        if (sent == items / 2 || $urandom_range(0, 15) == 0) hold_until_drained();
        send_value(random_value());
        sent++;
      end
    end
  endtask

  task automatic test_random_traffic();
    run_traffic_phase(17, 85, 48);
    run_traffic_phase(85, 17, 48);
    run_traffic_phase(0, 0, 48);
  endtask

  // ------------------------------------------------------------------------
  // sequence
  // ------------------------------------------------------------------------
  initial begin
    send_gap_pct   = 17;
    recv_stall_pct = 85;
    repeat (4) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_reset_decimal();
    test_unused_index();
    test_radix_extremes();
    test_bad_alphabets();
    test_random_traffic();

    // nothing outstanding, then watch for stray beats
    drain_and_settle();
    if (fault_count == 0 && expected_text.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // hang guard
  initial begin
    #(TIMEOUT_NS);
    $display("FAILED: results differ");
    $finish;
  end

endmodule
